@@ design/apr_pkg.sv @@
// ----------------------------------------------------------------------------
// apr_pkg: shared constants and types of the predictor restore unit
// Widths, code values and control bundles used by the cells, the MAC and top.
// ----------------------------------------------------------------------------
package apr_pkg;

  localparam int MAX_ORDER  = 32;
  localparam int DATA_W     = 32;
  localparam int COEF_W     = 16;
  localparam int ORDER_W    = 6;
  localparam int KIND_W     = 2;
  localparam int IDX_W      = 6;
  localparam int LPC_SHIFT  = 15;
  localparam int TAP_W      = $clog2(MAX_ORDER);
  localparam int POS_W      = $clog2(MAX_ORDER + 1);
  localparam int PROD_W     = DATA_W + COEF_W;
  localparam int ACC_W      = PROD_W + TAP_W;
  // Fixed order 4 needs DATA_W + 4 bits; LPC needs the shifted accumulator.
  localparam int PRED_W     = ((ACC_W - LPC_SHIFT) > (DATA_W + 4)) ?
                              (ACC_W - LPC_SHIFT) : (DATA_W + 4);
  localparam int SUM_W      = PRED_W + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  localparam int FIXED_MAX_ORDER = 4;
  localparam int FIR_ORDER       = 2;

  localparam logic [KIND_W-1:0] KIND_FIXED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIR   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LPC   = 2'd2;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_KIND  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 1'b1;

  typedef struct packed {
    logic clear;
    logic rotate;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic tap;
  } mac_ctrl_t;

endpackage

@@ design/apr_if.sv @@
// ----------------------------------------------------------------------------
// apr_if: valid/ready channels of the predictor restore unit
// Input channel carries residuals and coefficient loads, output carries samples.
// ----------------------------------------------------------------------------
interface apr_in_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic                              block_start;
  logic signed [apr_pkg::DATA_W-1:0] residual;
  logic        [apr_pkg::IDX_W-1:0]  coeff_index;
  logic signed [apr_pkg::COEF_W-1:0] coeff_value;

  modport source (output valid, opcode, block_start, residual, coeff_index, coeff_value,
                  input ready);
  modport sink (input valid, opcode, block_start, residual, coeff_index, coeff_value,
                output ready);
endinterface

interface apr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [apr_pkg::DATA_W-1:0] sample;
  logic                              block_error;

  modport source (output valid, sample, block_error, input ready);
  modport sink (input valid, sample, block_error, output ready);
endinterface

@@ design/apr_cell.sv @@
// ----------------------------------------------------------------------------
// apr_cell: one history/coefficient cell of the predictor ring
// Holds one past sample and one tap; rotates around the ring or shifts in order.
// ----------------------------------------------------------------------------
module apr_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  apr_pkg::cell_ctrl_t               ctrl_i,
  input  logic        [apr_pkg::DATA_W-1:0] hist_up_i,
  input  logic        [apr_pkg::DATA_W-1:0] hist_dn_i,
  input  logic signed [apr_pkg::COEF_W-1:0] coef_up_i,
  input  logic                              coef_we_i,
  input  logic signed [apr_pkg::COEF_W-1:0] coef_wdata_i,
  output logic        [apr_pkg::DATA_W-1:0] hist_o,
  output logic signed [apr_pkg::COEF_W-1:0] coef_o
);

  logic        [apr_pkg::DATA_W-1:0] hist_q, hist_d;
  logic signed [apr_pkg::COEF_W-1:0] coef_q, coef_d;

  always_comb begin
    hist_d = hist_q;
    if (ctrl_i.clear) begin
      hist_d = '0;
    end else if (ctrl_i.rotate) begin
      hist_d = hist_up_i;
    end else if (ctrl_i.shift) begin
      hist_d = hist_dn_i;
    end
  end

  always_comb begin
    coef_d = coef_q;
    if (ctrl_i.rotate) begin
      coef_d = coef_up_i;
    end else if (coef_we_i) begin
      coef_d = coef_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else begin
      hist_q <= hist_d;
    end
  end

  // taps are undefined until loaded
  always_ff @(posedge clk_i) begin
    coef_q <= coef_d;
  end

  assign hist_o = hist_q;
  assign coef_o = coef_q;

endmodule

@@ design/apr_mac.sv @@
// ----------------------------------------------------------------------------
// apr_mac: shared multiply-accumulate at the head of the ring
// Registers each tap product, then adds it into the accumulator in the cycle after.
// ----------------------------------------------------------------------------
module apr_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  apr_pkg::mac_ctrl_t                ctrl_i,
  input  logic signed [apr_pkg::COEF_W-1:0] coef_i,
  input  logic        [apr_pkg::DATA_W-1:0] hist_i,
  output logic signed [apr_pkg::ACC_W-1:0]  acc_o
);

  logic signed [apr_pkg::PROD_W-1:0] prod_q, prod_d;
  logic signed [apr_pkg::ACC_W-1:0]  acc_q, acc_d;

  always_comb begin
    prod_d = '0;
    if (ctrl_i.tap) begin
      prod_d = coef_i * $signed(hist_i);
    end
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.step) begin
      acc_d = acc_q + apr_pkg::ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      acc_q <= acc_d;
      if (ctrl_i.clear) begin
        prod_q <= '0;
      end else if (ctrl_i.step) begin
        prod_q <= prod_d;
      end
    end
  end

  assign acc_o = acc_q;

endmodule

@@ design/audio_predictor_restore_unit.sv @@
// ----------------------------------------------------------------------------
// audio_predictor_restore_unit: residual plus prediction to 32-bit samples
// Coefficient load: one transfer, no result; the unit is ready again next cycle.
// Fixed/FIR sample: ST_PRED registers the prediction, then ST_SUM adds it to the
// residual and fills the output register before the unit returns to idle. LPC
// sample: ST_MAC, ST_DRAIN, then ST_SUM; the single shared MAC walks all
// MAX_ORDER ring cells, one tap per cycle. A held result stalls the final add.
// One item in flight at a time; reset zeroes history, position, error, config.
// ----------------------------------------------------------------------------
module audio_predictor_restore_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  apr_in_if.sink                             in_i,
  apr_out_if.source                          out_o,
  input  logic                               cfg_we_i,
  input  logic [apr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [apr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_PRED,
    ST_SUM
  } state_e;

  state_e state_q;

  // configuration registers
  logic [apr_pkg::KIND_W-1:0]  kind_q;
  logic [apr_pkg::ORDER_W-1:0] order_q;

  // sequencing and block state
  logic [apr_pkg::TAP_W-1:0]   step_q;
  logic [apr_pkg::POS_W-1:0]   pos_q;
  logic                        err_q;
  logic                        inval_q;
  logic                        lpc_q;
  logic signed [apr_pkg::DATA_W-1:0] residual_q;
  logic signed [apr_pkg::PRED_W-1:0] pred_q;

  // output register
  logic                              out_valid_q;
  logic signed [apr_pkg::DATA_W-1:0] sample_q;
  logic                              out_err_q;

  logic in_fire, out_fire, is_sample, is_load, sum_fire;
  logic cfg_ok, cfg_lpc;

  // ring wires
  logic        [apr_pkg::DATA_W-1:0] hist_w [apr_pkg::MAX_ORDER];
  logic signed [apr_pkg::COEF_W-1:0] coef_w [apr_pkg::MAX_ORDER];
  apr_pkg::cell_ctrl_t               cell_ctrl;
  apr_pkg::mac_ctrl_t                mac_ctrl;
  logic signed [apr_pkg::ACC_W-1:0]  acc_w;

  logic signed [apr_pkg::PRED_W-1:0] x0, x1, x2, x3, fixed_pred, pred_sel;
  logic signed [apr_pkg::SUM_W-1:0]  sum_w;
  logic                              ovf, err_new;

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && out_o.ready;
  assign is_sample  = in_fire && (in_i.opcode == apr_pkg::OP_SAMPLE);
  assign is_load    = in_fire && (in_i.opcode == apr_pkg::OP_LOAD);
  // finish only when the output register is free or being drained this cycle
  assign sum_fire   = (state_q == ST_SUM) && (!out_valid_q || out_o.ready);

  // --------------------------------------------------------------------------
  // Configuration check: kind and order must form a legal pair
  // --------------------------------------------------------------------------
  always_comb begin
    cfg_ok = 1'b0;
    case (kind_q)
      apr_pkg::KIND_FIXED: cfg_ok = (int'(order_q) <= apr_pkg::FIXED_MAX_ORDER);
      apr_pkg::KIND_FIR:   cfg_ok = (int'(order_q) == apr_pkg::FIR_ORDER);
      apr_pkg::KIND_LPC:   cfg_ok = (order_q != '0) &&
                                    (int'(order_q) <= apr_pkg::MAX_ORDER);
      default:             cfg_ok = 1'b0;
    endcase
  end
  assign cfg_lpc = cfg_ok && (kind_q == apr_pkg::KIND_LPC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= '0;
      order_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        apr_pkg::REG_KIND:  kind_q  <= cfg_data_i[apr_pkg::KIND_W-1:0];
        apr_pkg::REG_ORDER: order_q <= cfg_data_i[apr_pkg::ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Cell ring. Cell 0 holds the newest sample. During MAC steps every cell
  // hands its sample and tap to the cell below, cell 0 wrapping to the top,
  // so after MAX_ORDER steps the ring is back in place. On a finished sample
  // the history shifts up by one and the new sample enters cell 0.
  // --------------------------------------------------------------------------
  assign cell_ctrl.clear  = is_sample && in_i.block_start;
  assign cell_ctrl.rotate = (state_q == ST_MAC);
  assign cell_ctrl.shift  = sum_fire;

  for (genvar i = 0; i < apr_pkg::MAX_ORDER; i++) begin : g_cell
    localparam int UP = (i + 1) % apr_pkg::MAX_ORDER;
    localparam int DN = (i == 0) ? 0 : i - 1;

    logic [apr_pkg::DATA_W-1:0] hist_dn;
    logic                       coef_we;

    assign hist_dn = (i == 0) ? sum_w[apr_pkg::DATA_W-1:0] : hist_w[DN];
    assign coef_we = is_load && (int'(in_i.coeff_index) == i + 1);

    apr_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .hist_up_i    (hist_w[UP]),
      .hist_dn_i    (hist_dn),
      .coef_up_i    (coef_w[UP]),
      .coef_we_i    (coef_we),
      .coef_wdata_i (in_i.coeff_value),
      .hist_o       (hist_w[i]),
      .coef_o       (coef_w[i])
    );
  end

  // --------------------------------------------------------------------------
  // Shared MAC on cell 0: step k sees original tap k; taps past the order
  // contribute zero. The drain step adds the last registered product.
  // --------------------------------------------------------------------------
  assign mac_ctrl.clear = is_sample;
  assign mac_ctrl.step  = (state_q == ST_MAC) || (state_q == ST_DRAIN);
  assign mac_ctrl.tap   = (state_q == ST_MAC) && (int'(step_q) < int'(order_q));

  apr_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .coef_i (coef_w[0]),
    .hist_i (hist_w[0]),
    .acc_o  (acc_w)
  );

  // --------------------------------------------------------------------------
  // Fixed polynomial and two-tap FIR prediction from the four newest samples
  // --------------------------------------------------------------------------
  assign x0 = apr_pkg::PRED_W'($signed(hist_w[0]));
  assign x1 = apr_pkg::PRED_W'($signed(hist_w[1]));
  assign x2 = apr_pkg::PRED_W'($signed(hist_w[2]));
  assign x3 = apr_pkg::PRED_W'($signed(hist_w[3]));

  always_comb begin
    fixed_pred = '0;
    // pass through until the block has order samples, and on a bad config
    if (!inval_q && (int'(pos_q) >= int'(order_q))) begin
      if (kind_q == apr_pkg::KIND_FIR) begin
        fixed_pred = ((x0 <<< 1) + x0 - x1) >>> 2;
      end else begin
        case (order_q)
          6'd1:    fixed_pred = x0;
          6'd2:    fixed_pred = (x0 <<< 1) - x1;
          6'd3:    fixed_pred = (x0 <<< 1) + x0 - (x1 <<< 1) - x1 + x2;
          6'd4:    fixed_pred = (x0 <<< 2) - (x1 <<< 2) - (x1 <<< 1) + (x2 <<< 2) - x3;
          default: fixed_pred = '0;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Final add and range check
  // --------------------------------------------------------------------------
  assign pred_sel = lpc_q ? apr_pkg::PRED_W'(acc_w >>> apr_pkg::LPC_SHIFT) : pred_q;
  assign sum_w    = apr_pkg::SUM_W'(residual_q) + apr_pkg::SUM_W'(pred_sel);
  assign ovf      = !((&sum_w[apr_pkg::SUM_W-1:apr_pkg::DATA_W-1]) ||
                      (~|sum_w[apr_pkg::SUM_W-1:apr_pkg::DATA_W-1]));
  assign err_new  = err_q || inval_q || ovf;

  // --------------------------------------------------------------------------
  // Sequencer and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      pos_q       <= '0;
      err_q       <= 1'b0;
      inval_q     <= 1'b0;
      lpc_q       <= 1'b0;
      residual_q  <= '0;
      pred_q      <= '0;
      out_valid_q <= 1'b0;
      sample_q    <= '0;
      out_err_q   <= 1'b0;
    end else begin
      // refill the result on a finished sample, drop it once it is taken
      if (sum_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (is_sample) begin
            residual_q <= in_i.residual;
            inval_q    <= !cfg_ok;
            lpc_q      <= cfg_lpc;
            step_q     <= '0;
            if (in_i.block_start) begin
              pos_q <= '0;
              err_q <= 1'b0;
            end
            state_q <= cfg_lpc ? ST_MAC : ST_PRED;
          end
        end
        ST_MAC: begin
          step_q <= step_q + 1'b1;
          if (step_q == apr_pkg::TAP_W'(apr_pkg::MAX_ORDER - 1)) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_SUM;
        end
        ST_PRED: begin
          pred_q  <= fixed_pred;
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          if (sum_fire) begin
            sample_q    <= sum_w[apr_pkg::DATA_W-1:0];
            out_err_q   <= err_new;
            err_q       <= err_new;
            if (pos_q != apr_pkg::POS_W'(apr_pkg::MAX_ORDER)) begin
              pos_q <= pos_q + 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.sample      = sample_q;
  assign out_o.block_error = out_err_q;

`ifndef SYNTHESIS
  // a new result only ever comes out of the final add
  a_result_from_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_SUM))
    else $error("result raised outside the final add");

  // a coefficient load never produces a result
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_i.opcode == apr_pkg::OP_LOAD)) |=> !$rose(out_valid_q))
    else $error("coefficient load produced a result");

  // an accepted residual always leaves idle
  a_sample_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_sample |=> (state_q != ST_IDLE))
    else $error("residual accepted without starting work");

  // position count saturates at the ring depth
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(pos_q) <= apr_pkg::MAX_ORDER)
    else $error("position count past ring depth");
`endif

endmodule
